### src/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants of the submodule fault protection block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

  localparam int unsigned MaxLanes   = 4;
  localparam int unsigned NumModules = 4;
  localparam int unsigned VoltW      = 16;
  localparam int unsigned CurrW      = 16;
  localparam int unsigned TicksW     = 12;
  localparam int unsigned CountW     = 13;
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [CountW-1:0] CountMax  = '1;
  localparam logic [CountW-1:0] HoldExtra = CountW'(3);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OV_THRESHOLD = 8'd0,
    CFG_OV_TICKS     = 8'd1,
    CFG_OC_THRESHOLD = 8'd2,
    CFG_OC_TICKS     = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        [VoltW-1:0]  ov_threshold;
    logic        [TicksW-1:0] ov_ticks;
    logic signed [CurrW-1:0]  oc_threshold;
    logic        [TicksW-1:0] oc_ticks;
  } cfg_t;

  typedef struct packed {
    logic        [VoltW-1:0]    module_voltage_1;
    logic        [VoltW-1:0]    module_voltage_2;
    logic        [VoltW-1:0]    module_voltage_3;
    logic        [VoltW-1:0]    module_voltage_4;
    logic signed [CurrW-1:0]    bridge_current;
    logic        [MaxLanes-1:0] driver_ok_lines;
    logic        [MaxLanes-1:0] no_short_lines;
    logic        [MaxLanes-1:0] temp_ok_lines;
    logic                       link_lost;
  } in_item_t;

  typedef struct packed {
    logic [MaxLanes-1:0] driver_faults;
    logic [MaxLanes-1:0] short_faults;
    logic [MaxLanes-1:0] overtemp_faults;
    logic [MaxLanes-1:0] overvoltage_faults;
    logic                overcurrent_fault;
    logic                link_fault;
  } out_item_t;

endpackage

`default_nettype wire

### src/submodule_fault_protection_unit.sv
// ----------------------------------------------------------------------------
// submodule_fault_protection_unit
// Overvoltage and overcurrent protection with persistence timers, latched
// comm fault and pass-through status faults for up to four submodules.
// ----------------------------------------------------------------------------
// One protection tick is taken per clock cycle unless the receiver stalls. An
// accepted item lands in the input register; when the output register is free
// the compares, persistence counters and latches update and the result moves
// into the output register, where it is offered to the receiver.
// Throughput is one item per cycle when the receiver does not stall, set by the
// two-register pipeline; in_ready_o follows out_ready_i combinationally when
// both registers hold items. Latches clear only at reset.
`default_nettype none

module submodule_fault_protection_unit
  import sfp_pkg::*;
#(
  parameter int unsigned NUM_MODULES = NumModules
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire in_item_t            in_item_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      out_item_t           out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned Lanes = (NUM_MODULES < MaxLanes) ? NUM_MODULES : MaxLanes;
  localparam logic [MaxLanes-1:0] LaneMask = MaxLanes'((1 << Lanes) - 1);

  cfg_t      cfg;
  in_item_t  s1_item_q;
  logic      s1_valid_q;
  out_item_t out_item_q, out_item_d;
  logic      out_valid_q;
  logic      s1_fire, out_free;

  logic [VoltW-1:0]    volt [MaxLanes];
  logic [Lanes-1:0]    ov_set;
  logic [MaxLanes-1:0] ov_latch_q, ov_latch_d;
  logic                oc_set, oc_latch_q, oc_latch_d;
  logic                comm_latch_q, comm_latch_d;

  sfp_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  // pipeline handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
    if (s1_fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign volt[0] = s1_item_q.module_voltage_1;
  assign volt[1] = s1_item_q.module_voltage_2;
  assign volt[2] = s1_item_q.module_voltage_3;
  assign volt[3] = s1_item_q.module_voltage_4;

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    sfp_persist u_ov (
      .clk_i,
      .rst_ni,
      .en_i    (s1_fire),
      .hit_i   (volt[g] > cfg.ov_threshold),
      .ticks_i (cfg.ov_ticks),
      .set_o   (ov_set[g])
    );
  end

  sfp_persist u_oc (
    .clk_i,
    .rst_ni,
    .en_i    (s1_fire),
    .hit_i   ($signed(s1_item_q.bridge_current) >= $signed(cfg.oc_threshold)),
    .ticks_i (cfg.oc_ticks),
    .set_o   (oc_set)
  );

  always_comb begin
    ov_latch_d   = ov_latch_q | (MaxLanes'(ov_set) & LaneMask);
    oc_latch_d   = oc_latch_q | oc_set;
    comm_latch_d = comm_latch_q | s1_item_q.link_lost;

    out_item_d.driver_faults      = ~s1_item_q.driver_ok_lines & LaneMask;
    out_item_d.short_faults       = ~s1_item_q.no_short_lines & LaneMask;
    out_item_d.overtemp_faults    = ~s1_item_q.temp_ok_lines & LaneMask;
    out_item_d.overvoltage_faults = ov_latch_d;
    out_item_d.overcurrent_fault  = oc_latch_d;
    out_item_d.link_fault         = comm_latch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_latch_q   <= '0;
      oc_latch_q   <= 1'b0;
      comm_latch_q <= 1'b0;
    end else if (s1_fire) begin
      ov_latch_q   <= ov_latch_d;
      oc_latch_q   <= oc_latch_d;
      comm_latch_q <= comm_latch_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  a_ov_latch_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ov_latch_q & $past(ov_latch_q)) == $past(ov_latch_q)))
    else $error("overvoltage latch cleared without reset");

  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("item lost between input and output register");

  a_comm_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_item_q.link_lost) |=> (comm_latch_q && out_item_q.link_fault))
    else $error("link loss did not latch comm fault");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with free pipeline slot");
`endif

endmodule

`default_nettype wire

### src/sfp_cfg.sv
// ----------------------------------------------------------------------------
// sfp_cfg
// Configuration register file: thresholds and persistence tick counts.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_cfg
  import sfp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output      cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_OV_THRESHOLD: cfg_d.ov_threshold = cfg_data_i[VoltW-1:0];
        CFG_OV_TICKS:     cfg_d.ov_ticks     = cfg_data_i[TicksW-1:0];
        CFG_OC_THRESHOLD: cfg_d.oc_threshold = $signed(cfg_data_i[CurrW-1:0]);
        CFG_OC_TICKS:     cfg_d.oc_ticks     = cfg_data_i[TicksW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ov_threshold <= '1;
      cfg_q.ov_ticks     <= TicksW'(10);
      cfg_q.oc_threshold <= {1'b0, {(CurrW-1){1'b1}}};
      cfg_q.oc_ticks     <= TicksW'(10);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### src/sfp_persist.sv
// ----------------------------------------------------------------------------
// sfp_persist
// Persistence counter: counts consecutive hits and flags when the set time
// is reached, then holds the count at ticks plus three.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_persist
  import sfp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              hit_i,
  input  wire logic [TicksW-1:0] ticks_i,
  output      logic              set_o
);

  logic [CountW-1:0] cnt_q, cnt_d, cnt_inc, ticks_ext;

  assign ticks_ext = {1'b0, ticks_i};
  assign cnt_inc   = (cnt_q != CountMax) ? cnt_q + CountW'(1) : cnt_q;
  assign set_o     = hit_i && (cnt_inc >= ticks_ext);

  always_comb begin
    cnt_d = cnt_q;
    if (en_i) begin
      if (!hit_i) begin
        cnt_d = '0;
      end else if (set_o) begin
        cnt_d = ticks_ext + HoldExtra;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### sim/fault_word_checker.sv
// ----------------------------------------------------------------------------
// fault_word_checker
// Watches the tick and fault channels of the submodule fault protection unit,
// keeps its own copy of the persistence counters, latches and settings, and
// compares every fault word taken by the receiver with the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fault_word_checker
  import sfp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_item_t            in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_item_t           out_item_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  error_count_o,
  output int                  pending_o
);

  localparam int unsigned Lanes = (NumModules < MaxLanes) ? NumModules : MaxLanes;
  localparam logic [MaxLanes-1:0] LaneMask = MaxLanes'((1 << Lanes) - 1);

  cfg_t                tick_cfg;
  logic [CountW-1:0]   volt_run [MaxLanes];
  logic [CountW-1:0]   curr_run;
  logic [MaxLanes-1:0] ov_latched;
  logic                oc_latched;
  logic                comm_latched;
  out_item_t           fault_word_q [$];
  out_item_t           want;
  int                  error_count = 0;

  assign error_count_o = error_count;

  // returns {trip, next run length}
  function automatic logic [CountW:0] advance_run(input logic [CountW-1:0] run,
                                                  input logic hit,
                                                  input logic [TicksW-1:0] ticks);
    logic [CountW-1:0] inc;
    logic [CountW-1:0] goal;
    if (!hit) return '0;
    inc  = (run < CountMax) ? run + 1'b1 : run;
    goal = CountW'(ticks);
    if (inc >= goal) return {1'b1, goal + HoldExtra};
    return {1'b0, inc};
  endfunction

  task automatic predict_tick(input in_item_t it);
    logic [VoltW-1:0] volts [MaxLanes];
    logic [CountW:0]  step;
    out_item_t        word;
    volts[0] = it.module_voltage_1;
    volts[1] = it.module_voltage_2;
    volts[2] = it.module_voltage_3;
    volts[3] = it.module_voltage_4;
    for (int i = 0; i < Lanes; i++) begin
      step = advance_run(volt_run[i], volts[i] > tick_cfg.ov_threshold, tick_cfg.ov_ticks);
      volt_run[i] = step[CountW-1:0];
      if (step[CountW]) ov_latched[i] = 1'b1;
    end
    step = advance_run(curr_run,
                       $signed(it.bridge_current) >= $signed(tick_cfg.oc_threshold),
                       tick_cfg.oc_ticks);
    curr_run = step[CountW-1:0];
    if (step[CountW]) oc_latched = 1'b1;
    if (it.link_lost) comm_latched = 1'b1;
    word.driver_faults      = ~it.driver_ok_lines & LaneMask;
    word.short_faults       = ~it.no_short_lines & LaneMask;
    word.overtemp_faults    = ~it.temp_ok_lines & LaneMask;
    word.overvoltage_faults = ov_latched & LaneMask;
    word.overcurrent_fault  = oc_latched;
    word.link_fault         = comm_latched;
    fault_word_q.push_back(word);
  endtask

  task automatic check_field(input string name, input logic [MaxLanes-1:0] exp_v,
                             input logic [MaxLanes-1:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      if (error_count <= 10)
        $display("mismatch in %s: expected %h, got %h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_cfg.ov_threshold = '1;
      tick_cfg.ov_ticks     = TicksW'(10);
      tick_cfg.oc_threshold = 16'sh7fff;
      tick_cfg.oc_ticks     = TicksW'(10);
      for (int i = 0; i < MaxLanes; i++) volt_run[i] = '0;
      curr_run     = '0;
      ov_latched   = '0;
      oc_latched   = 1'b0;
      comm_latched = 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_OV_THRESHOLD: tick_cfg.ov_threshold = cfg_data_i;
          CFG_OV_TICKS:     tick_cfg.ov_ticks     = cfg_data_i[TicksW-1:0];
          CFG_OC_THRESHOLD: tick_cfg.oc_threshold = cfg_data_i;
          CFG_OC_TICKS:     tick_cfg.oc_ticks     = cfg_data_i[TicksW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_tick(in_item_i);
      if (out_valid_i && out_ready_i) begin
        if (fault_word_q.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected fault word %h", out_item_i);
        end else begin
          want = fault_word_q.pop_front();
          check_field("driver_faults", want.driver_faults, out_item_i.driver_faults);
          check_field("short_faults", want.short_faults, out_item_i.short_faults);
          check_field("overtemp_faults", want.overtemp_faults, out_item_i.overtemp_faults);
          check_field("overvoltage_faults", want.overvoltage_faults,
                      out_item_i.overvoltage_faults);
          check_field("overcurrent_fault", MaxLanes'(want.overcurrent_fault),
                      MaxLanes'(out_item_i.overcurrent_fault));
          check_field("link_fault", MaxLanes'(want.link_fault),
                      MaxLanes'(out_item_i.link_fault));
        end
      end
    end
    pending_o = fault_word_q.size();
  end

endmodule

### sim/submodule_fault_protection_unit_tb.sv
// ----------------------------------------------------------------------------
// submodule_fault_protection_unit_tb
// Drives protection ticks into the fault protection unit: a directed opening
// on the reset settings, the zero and lowered tick settings and the field
// extremes, then three random phases with run-shaped voltage and current
// sequences under different settings and idling, a long receiver hold-off
// and a drain pause. The checker beside the block judges every fault word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module submodule_fault_protection_unit_tb
  import sfp_pkg::*;
();

  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 60;
  localparam int TailCycles  = 6;
  localparam int PhaseTicks  = 545;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  in_item_t            in_item     = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  out_item_t           out_item;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;
  int                  error_count;
  int                  pending;

  int  sender_idle_pct = 0;
  int  recv_idle_pct   = 0;
  logic hold_req       = 1'b0;
  int  hold_left       = 0;
  int  cycle_count     = 0;

  int  ov_thr_set   = 65535;
  int  ov_ticks_set = 10;
  int  oc_thr_set   = 32767;
  int  oc_ticks_set = 10;
  int  run_left [5] = '{default: 0};
  bit  run_hit  [5] = '{default: 1'b0};

  submodule_fault_protection_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  fault_word_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_left = HoldCycles - 1;
      hold_req  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic in_item_t make_item(input int v1, input int v2, input int v3,
                                         input int v4, input int cur,
                                         input logic [3:0] drv, input logic [3:0] nsh,
                                         input logic [3:0] tmp, input logic link);
    in_item_t it;
    it.module_voltage_1 = VoltW'(v1);
    it.module_voltage_2 = VoltW'(v2);
    it.module_voltage_3 = VoltW'(v3);
    it.module_voltage_4 = VoltW'(v4);
    it.bridge_current   = CurrW'(cur);
    it.driver_ok_lines  = drv;
    it.no_short_lines   = nsh;
    it.temp_ok_lines    = tmp;
    it.link_lost        = link;
    return it;
  endfunction

  task automatic send_tick(input in_item_t it);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(data);
    case (idx)
      CFG_OV_THRESHOLD: ov_thr_set   = data & 16'hffff;
      CFG_OV_TICKS:     ov_ticks_set = data & 12'hfff;
      CFG_OC_THRESHOLD: oc_thr_set   = int'($signed(CurrW'(data)));
      CFG_OC_TICKS:     oc_ticks_set = data & 12'hfff;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_limits(input int ov_thr, input int ov_ticks, input int oc_thr,
                            input int oc_ticks);
    write_reg(CFG_OV_THRESHOLD, ov_thr);
    write_reg(CFG_OV_TICKS, ov_ticks);
    write_reg(CFG_OC_THRESHOLD, oc_thr);
    write_reg(CFG_OC_TICKS, oc_ticks);
    cfg_we <= 1'b0;
  endtask

  // runs of over-threshold samples, mostly shorter than the tick setting
  task automatic next_hit(input int lane, input int ticks, output bit hit);
    int span;
    if (run_left[lane] == 0) begin
      run_hit[lane] = ($urandom_range(0, 99) < 60);
      if (!run_hit[lane]) begin
        run_left[lane] = $urandom_range(1, 4);
      end else if (ticks <= 1) begin
        run_left[lane] = $urandom_range(1, 3);
      end else begin
        span = (ticks > 200) ? 300 : ticks - 1;
        run_left[lane] = ($urandom_range(0, 99) < 95) ? $urandom_range(1, span)
                                                      : $urandom_range(ticks, ticks + 4);
      end
    end
    run_left[lane] = run_left[lane] - 1;
    hit = run_hit[lane];
  endtask

  function automatic int volt_sample(input bit hit);
    if (hit) begin
      if (ov_thr_set == 65535) return 65535;
      return $urandom_range(0, 1) ? ov_thr_set + 1 : $urandom_range(ov_thr_set + 1, 65535);
    end
    return ($urandom_range(0, 3) == 0) ? ov_thr_set : $urandom_range(0, ov_thr_set);
  endfunction

  function automatic int curr_sample(input bit hit);
    if (hit) begin
      if ($urandom_range(0, 2) == 0) return oc_thr_set;
      return oc_thr_set + int'($urandom_range(0, 32767 - oc_thr_set));
    end
    if (oc_thr_set == -32768) return oc_thr_set;
    if ($urandom_range(0, 2) == 0) return oc_thr_set - 1;
    return oc_thr_set - 1 - int'($urandom_range(0, oc_thr_set + 32767));
  endfunction

  task automatic shape_tick(output in_item_t it);
    logic [95:0] raw;
    bit          hit [5];
    if ($urandom_range(0, 99) < 10) begin
      raw = {$urandom(), $urandom(), $urandom()};
      it  = raw[$bits(in_item_t)-1:0];
    end else begin
      for (int i = 0; i < 4; i++) next_hit(i, ov_ticks_set, hit[i]);
      next_hit(4, oc_ticks_set, hit[4]);
      it = make_item(volt_sample(hit[0]), volt_sample(hit[1]), volt_sample(hit[2]),
                     volt_sample(hit[3]), curr_sample(hit[4]),
                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)), ($urandom_range(0, 99) < 2));
    end
  endtask

  task automatic run_phase(input int n, input int s_idle, input int r_idle,
                           input bit with_hold, input bit with_pause);
    in_item_t it;
    sender_idle_pct <= s_idle;
    recv_idle_pct   <= r_idle;
    for (int k = 0; k < n; k++) begin
      if (with_hold && k == n / 3) hold_req <= 1'b1;
      if (with_pause && k == n / 2) drain_results();
      shape_tick(it);
      send_tick(it);
    end
    drain_results();
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: voltage at max never exceeds, current at max counts
    send_tick(make_item(65535, 65535, 65535, 65535, -32768, 4'h0, 4'h0, 4'h0, 1'b0));
    send_tick(make_item(0, 0, 0, 0, 32766, 4'hf, 4'hf, 4'hf, 1'b0));
    repeat (5) send_tick(make_item(65535, 0, 65535, 0, 32767, 4'ha, 4'h5, 4'h3, 1'b0));
    send_tick(make_item(65535, 0, 65535, 0, 32766, 4'h5, 4'ha, 4'hc, 1'b0));
    drain_results();

    // build up counts under the longest tick settings
    set_limits(40000, 4095, -32768, 4095);
    repeat (6) send_tick(make_item(40000, 40000, 40000, 40001, -32768, 4'hf, 4'hf, 4'hf,
                                   1'b0));
    drain_results();

    // zero tick setting: fresh lane trips at once, held lane meets the lowered value
    write_reg(CFG_OV_TICKS, 0);
    cfg_we <= 1'b0;
    send_tick(make_item(40001, 40000, 40000, 40001, 0, 4'hf, 4'hf, 4'hf, 1'b0));
    send_tick(make_item(40001, 40000, 40000, 40001, 32767, 4'h9, 4'h6, 4'h1, 1'b1));
    send_tick(make_item(0, 0, 0, 0, 32767, 4'hf, 4'hf, 4'hf, 1'b0));
    drain_results();

    set_limits($urandom_range(20000, 50000), $urandom_range(20, 60), $urandom_range(0, 65535),
               $urandom_range(20, 60));
    run_phase(PhaseTicks, 28, 81, 1'b1, 1'b0);

    set_limits(0, 4095, 32767, 1);
    run_phase(PhaseTicks, 81, 28, 1'b0, 1'b1);

    set_limits(65535, 1, -32768, 4095);
    write_reg(CfgIdxW'(CFG_OC_TICKS) + CfgIdxW'($urandom_range(1, 252)), $urandom_range(0, 65535));
    cfg_we <= 1'b0;
    run_phase(PhaseTicks, 0, 0, 1'b0, 1'b0);

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
